>>> design/tlpc_pkg.sv
// Shared constants and types for the tree ancestor engine.
// No dependencies; imported by the top level and the power unit.
`default_nettype none
package tlpc_pkg;
    localparam int NODE_W  = 11;
    localparam int LEVEL_W = 10;
    localparam int ODD_W   = 30;
    localparam int CMD_W   = 2;

    localparam int DEF_MAX_NODES   = 1024;
    localparam int DEF_LIFT_LEVELS = 11;

    localparam logic [ODD_W-1:0] PRIME_MOD = 30'd1000000007;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BUILD = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    typedef logic [NODE_W-1:0]  t_node;
    typedef logic [LEVEL_W-1:0] t_level;
    typedef logic [ODD_W-1:0]   t_odd;
endpackage
`default_nettype wire

>>> design/tlpc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module tlpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

>>> design/tlpc_pow2.sv
// Iterative 2^e mod prime: left-to-right square-and-double with a
// bit-serial modular multiplier (one add/reduce step per cycle). Uses tlpc_pkg.
`default_nettype none
module tlpc_pow2
    import tlpc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [LEVEL_W-1:0] i_exp,
    output logic                    o_busy,
    output logic                    o_done,
    output logic [ODD_W-1:0]        o_result
);
    localparam logic [2:0] P_IDLE = 3'd0;
    localparam logic [2:0] P_CHK  = 3'd1;
    localparam logic [2:0] P_SQ   = 3'd2;
    localparam logic [2:0] P_DBL  = 3'd3;
    localparam logic [2:0] P_DONE = 3'd4;

    logic [2:0]         r_state, n_state;
    logic [LEVEL_W-1:0] r_e, n_e;
    logic [3:0]         r_j, n_j;
    logic [4:0]         r_i, n_i;
    logic [ODD_W-1:0]   r_res, n_res;
    logic [ODD_W-1:0]   r_acc, n_acc;

    logic [ODD_W:0]     w_acc2, w_t1, w_sum, w_dbl;
    logic [ODD_W-1:0]   w_step, w_dres;

    // one multiplier step: acc = 2*acc + bit*res, reduced mod prime
    always_comb begin
        w_acc2 = {r_acc, 1'b0};
        w_t1   = (w_acc2 >= {1'b0, PRIME_MOD}) ? w_acc2 - {1'b0, PRIME_MOD} : w_acc2;
        w_sum  = r_res[r_i] ? w_t1 + {1'b0, r_res} : w_t1;
        w_step = (w_sum >= {1'b0, PRIME_MOD}) ? ODD_W'(w_sum - {1'b0, PRIME_MOD})
                                              : ODD_W'(w_sum);
        w_dbl  = {r_res, 1'b0};
        w_dres = (w_dbl >= {1'b0, PRIME_MOD}) ? ODD_W'(w_dbl - {1'b0, PRIME_MOD})
                                              : ODD_W'(w_dbl);
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_e     = r_e;
        n_j     = r_j;
        n_i     = r_i;
        n_res   = r_res;
        n_acc   = r_acc;
        case (r_state)
            P_IDLE: begin
                if (i_start) begin
                    n_e     = i_exp;
                    n_j     = 4'(LEVEL_W - 1);
                    n_res   = ODD_W'(1);
                    n_state = P_CHK;
                end
            end
            P_CHK: begin
                // squaring one gives one: skip it
                if (r_res == ODD_W'(1)) begin
                    n_state = P_DBL;
                end else begin
                    n_acc   = '0;
                    n_i     = 5'(ODD_W - 1);
                    n_state = P_SQ;
                end
            end
            P_SQ: begin
                n_acc = w_step;
                if (r_i == 5'd0) begin
                    n_res   = w_step;
                    n_state = P_DBL;
                end else begin
                    n_i = r_i - 5'd1;
                end
            end
            P_DBL: begin
                if (r_e[r_j]) begin
                    n_res = w_dres;
                end
                if (r_j == 4'd0) begin
                    n_state = P_DONE;
                end else begin
                    n_j     = r_j - 4'd1;
                    n_state = P_CHK;
                end
            end
            P_DONE: begin
                n_state = P_IDLE;
            end
            default: begin
                n_state = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= P_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_e   <= n_e;
        r_j   <= n_j;
        r_i   <= n_i;
        r_res <= n_res;
        r_acc <= n_acc;
    end

    assign o_busy   = (r_state != P_IDLE);
    assign o_done   = (r_state == P_DONE);
    assign o_result = r_res;
endmodule
`default_nettype wire

>>> design/tree_lca_path_parity_counter.sv
// Binary-lifting ancestor engine. A build is paced by the single read port of the
// ancestor RAM (two dependent reads per table entry). A query makes two lifting
// passes on the same port, then 2^(d-1) mod 1000000007 in the bit-serial modular
// multiplier. The block takes one transaction at a time; a finished result waits
// in the output register while the next transaction is taken.
// Ancestor and depth RAMs are not cleared: read a node only after loading it.
// Uses tlpc_pkg, tlpc_ram and tlpc_pow2.
`default_nettype none
module tree_lca_path_parity_counter
    import tlpc_pkg::*;
#(
    parameter int MAX_NODES   = DEF_MAX_NODES,
    parameter int LIFT_LEVELS = DEF_LIFT_LEVELS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [10:0] i_cfg_data,    // node_count
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // node_a, node_b, node_level
    input  wire logic [1:0]  s_axis_tuser,  // cmd
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,  // common_ancestor, path_length, odd_ways, zero pad
    output logic             m_axis_tuser   // status
);
    localparam int NIW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int KW  = $clog2(LIFT_LEVELS);
    localparam int AW  = NIW + KW;
    localparam logic [KW-1:0] K_TOP = KW'(LIFT_LEVELS - 1);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_BLD_A  = 5'd1;
    localparam logic [4:0] S_BLD_B  = 5'd2;
    localparam logic [4:0] S_BLD_C  = 5'd3;
    localparam logic [4:0] S_QA     = 5'd4;
    localparam logic [4:0] S_QB     = 5'd5;
    localparam logic [4:0] S_QC     = 5'd6;
    localparam logic [4:0] S_UP     = 5'd7;
    localparam logic [4:0] S_UPW    = 5'd8;
    localparam logic [4:0] S_CMP    = 5'd9;
    localparam logic [4:0] S_P2A    = 5'd10;
    localparam logic [4:0] S_P2B    = 5'd11;
    localparam logic [4:0] S_P2C    = 5'd12;
    localparam logic [4:0] S_PAR    = 5'd13;
    localparam logic [4:0] S_PARW   = 5'd14;
    localparam logic [4:0] S_DC     = 5'd15;
    localparam logic [4:0] S_DCW    = 5'd16;
    localparam logic [4:0] S_POW    = 5'd17;
    localparam logic [4:0] S_FIN    = 5'd18;

    function automatic logic node_ok(input t_node v);
        return (v != '0) && (32'(v) <= MAX_NODES);
    endfunction

    function automatic logic [NIW-1:0] node_idx(input t_node v);
        return NIW'(v - NODE_W'(1));
    endfunction

    function automatic logic [AW-1:0] anc_addr(input t_node v, input logic [KW-1:0] k);
        return {node_idx(v), k};
    endfunction

    logic [4:0]       r_state, n_state;
    t_node            r_cnt, n_cnt;
    t_node            r_a, n_a, r_b, n_b, r_c, n_c, r_ua, n_ua;
    t_level           r_da, n_da, r_db, n_db, r_diff, n_diff, r_pl, n_pl;
    logic [KW-1:0]    r_k, n_k;
    t_node            r_v, n_v;
    logic             r_st, n_st;
    logic             r_ovalid;
    logic             r_ost;
    t_node            r_oca;
    t_level           r_opl;
    t_odd             r_oodd;

    logic             w_accept, w_fin_go;
    t_node            w_lim, w_in_a, w_in_b;
    t_level           w_in_lvl, w_dc, w_d;
    logic [CMD_W-1:0] w_cmd;
    logic             w_anc_we, w_dep_we;
    logic [AW-1:0]    w_anc_waddr, w_anc_raddr;
    t_node            w_anc_wdata, w_anc_rdata;
    logic [NIW-1:0]   w_dep_raddr;
    t_level           w_dep_rdata;
    logic             w_pow_start, w_pow_busy, w_pow_done;
    t_odd             w_pow_res;
    logic [31:0]      w_diff_sh;
    logic             w_next_k_last;

    assign w_cmd    = s_axis_tuser;
    assign w_in_a   = s_axis_tdata[10:0];
    assign w_in_b   = s_axis_tdata[21:11];
    assign w_in_lvl = s_axis_tdata[31:22];
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_lim    = (32'(r_cnt) > MAX_NODES) ? NODE_W'(MAX_NODES) : r_cnt;
    assign w_fin_go = (r_state == S_FIN) && (!r_ovalid || m_axis_tready);
    assign w_diff_sh = 32'(r_diff) >> r_k;
    assign w_next_k_last = (r_k == '0);
    assign w_dc = node_ok(r_c) ? w_dep_rdata : '0;
    assign w_d  = r_da - w_dc + r_db - w_dc;

    // sequencer and datapath
    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_a = r_a; n_b = r_b; n_c = r_c; n_ua = r_ua;
        n_da = r_da; n_db = r_db; n_diff = r_diff; n_pl = r_pl;
        n_k = r_k; n_v = r_v; n_st = r_st;
        w_anc_we = 1'b0; w_dep_we = 1'b0;
        w_anc_waddr = anc_addr(w_in_a, '0);
        w_anc_wdata = w_in_b;
        w_anc_raddr = anc_addr(r_a, r_k);
        w_dep_raddr = node_idx(r_a);
        w_pow_start = 1'b0;
        if (i_cfg_valid) begin
            n_cnt = i_cfg_data;
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_st = 1'b1; n_c = '0; n_pl = '0;
                    n_a = w_in_a; n_b = w_in_b;
                    n_state = S_FIN;
                    if (w_cmd == CMD_LOAD) begin
                        w_anc_we = node_ok(w_in_a);
                        w_dep_we = node_ok(w_in_a);
                    end else if (w_cmd == CMD_BUILD) begin
                        n_v = NODE_W'(1);
                        n_k = KW'(1);
                        if (w_lim != '0) begin
                            n_state = S_BLD_A;
                        end
                    end else if (w_cmd == CMD_QUERY) begin
                        n_st = 1'b0;
                        if (w_in_a != '0 && w_in_b != '0 && w_in_a <= w_lim &&
                            w_in_b <= w_lim) begin
                            n_state = S_QA;
                        end
                    end
                end
            end
            S_BLD_A: begin
                w_anc_raddr = anc_addr(r_v, KW'(r_k - KW'(1)));
                n_state = S_BLD_B;
            end
            S_BLD_B: begin
                n_ua = w_anc_rdata;
                w_anc_raddr = anc_addr(w_anc_rdata, KW'(r_k - KW'(1)));
                n_state = S_BLD_C;
            end
            S_BLD_C: begin
                w_anc_we = 1'b1;
                w_anc_waddr = anc_addr(r_v, r_k);
                w_anc_wdata = node_ok(r_ua) ? w_anc_rdata : '0;
                n_state = S_BLD_A;
                if (r_v == w_lim) begin
                    n_v = NODE_W'(1);
                    if (r_k == K_TOP) begin
                        n_state = S_FIN;
                    end else begin
                        n_k = r_k + KW'(1);
                    end
                end else begin
                    n_v = r_v + NODE_W'(1);
                end
            end
            S_QA: begin
                n_state = S_QB;
            end
            S_QB: begin
                n_da = w_dep_rdata;
                w_dep_raddr = node_idx(r_b);
                n_state = S_QC;
            end
            S_QC: begin
                // put the deeper endpoint in a
                if (r_da < w_dep_rdata) begin
                    n_a = r_b; n_b = r_a;
                    n_da = w_dep_rdata; n_db = r_da;
                    n_diff = w_dep_rdata - r_da;
                end else begin
                    n_db = w_dep_rdata;
                    n_diff = r_da - w_dep_rdata;
                end
                n_k = K_TOP;
                n_state = S_UP;
            end
            S_UP: begin
                // lift a by the set bits of the depth difference
                if (w_diff_sh[0] && node_ok(r_a)) begin
                    n_state = S_UPW;
                end else begin
                    if (w_diff_sh[0]) begin
                        n_a = '0;
                    end
                    if (w_next_k_last) n_state = S_CMP;
                    else n_k = r_k - KW'(1);
                end
            end
            S_UPW: begin
                n_a = w_anc_rdata;
                if (w_next_k_last) begin
                    n_state = S_CMP;
                end else begin
                    n_k = r_k - KW'(1);
                    n_state = S_UP;
                end
            end
            S_CMP: begin
                if (r_a == r_b) begin
                    n_c = r_a;
                    n_state = S_DC;
                end else begin
                    n_k = K_TOP;
                    n_state = S_P2A;
                end
            end
            S_P2A: begin
                n_state = S_P2B;
            end
            S_P2B: begin
                n_ua = node_ok(r_a) ? w_anc_rdata : '0;
                w_anc_raddr = anc_addr(r_b, r_k);
                n_state = S_P2C;
            end
            S_P2C: begin
                if (node_ok(r_b) && r_ua != w_anc_rdata && r_ua != '0 &&
                    w_anc_rdata != '0) begin
                    n_a = r_ua;
                    n_b = w_anc_rdata;
                end
                if (w_next_k_last) begin
                    n_state = S_PAR;
                end else begin
                    n_k = r_k - KW'(1);
                    n_state = S_P2A;
                end
            end
            S_PAR: begin
                w_anc_raddr = anc_addr(r_a, '0);
                n_state = S_PARW;
            end
            S_PARW: begin
                n_c = node_ok(r_a) ? w_anc_rdata : '0;
                n_state = S_DC;
            end
            S_DC: begin
                w_dep_raddr = node_idx(r_c);
                n_state = S_DCW;
            end
            S_DCW: begin
                n_pl = w_d;
                if (w_d == '0) begin
                    n_state = S_FIN;
                end else begin
                    w_pow_start = 1'b1;
                    n_state = S_POW;
                end
            end
            S_POW: begin
                if (w_pow_done) n_state = S_FIN;
            end
            S_FIN: begin
                if (w_fin_go) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= NODE_W'(1);
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            // hold the result until the transaction is taken
            if (w_fin_go) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
        end
        r_a <= n_a; r_b <= n_b; r_c <= n_c; r_ua <= n_ua;
        r_da <= n_da; r_db <= n_db; r_diff <= n_diff; r_pl <= n_pl;
        r_k <= n_k; r_v <= n_v; r_st <= n_st;
        if (w_fin_go) begin
            r_ost  <= r_st;
            r_oca  <= r_c;
            r_opl  <= r_pl;
            r_oodd <= (r_pl == '0) ? '0 : w_pow_res;
        end
    end

    tlpc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES * (1 << KW))) u_anc (
        .i_clk(i_clk), .i_we(w_anc_we), .i_waddr(w_anc_waddr), .i_wdata(w_anc_wdata),
        .i_raddr(w_anc_raddr), .o_rdata(w_anc_rdata)
    );

    tlpc_ram #(.WIDTH(LEVEL_W), .DEPTH(MAX_NODES)) u_dep (
        .i_clk(i_clk), .i_we(w_dep_we), .i_waddr(node_idx(w_in_a)), .i_wdata(w_in_lvl),
        .i_raddr(w_dep_raddr), .o_rdata(w_dep_rdata)
    );

    tlpc_pow2 u_pow (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_pow_start),
        .i_exp(LEVEL_W'(w_d - LEVEL_W'(1))), .o_busy(w_pow_busy),
        .o_done(w_pow_done), .o_result(w_pow_res)
    );

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_ost;
    assign m_axis_tdata  = {5'd0, r_oodd, r_opl, r_oca};

    // an accepted transaction always leaves idle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE)) else $error("accept did not start work");
    // RAM writes only on a load or a build step
    a_write_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_anc_we || w_dep_we) |-> ((r_state == S_IDLE && w_accept) ||
        (r_state == S_BLD_C))) else $error("stray table write");
    // power unit is started only when free
    a_pow_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pow_start |-> !w_pow_busy) else $error("power unit restarted");
    // a finished result shows up on the next cycle
    a_fin_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin_go |=> m_axis_tvalid) else $error("result lost");
endmodule
`default_nettype wire

>>> test/tree_lca_path_parity_counter_checker.sv
// Scoreboard for the tree ancestor engine: watches the config, input and result channels.
// Keeps its own ancestor and depth tables and predicts every result transaction.
// Depends on tlpc_pkg.
`timescale 1ns / 100ps
module tree_lca_path_parity_counter_checker
    import tlpc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [10:0] i_cfg_data,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [31:0] i_s_tdata,
    input  wire logic [1:0]  i_s_tuser,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [55:0] i_m_tdata,
    input  wire logic        i_m_tuser,
    output int               o_fail_count,
    output int               o_pending
);
    localparam int TREE_NODES = DEF_MAX_NODES;
    localparam int LEVELS     = DEF_LIFT_LEVELS;
    localparam logic ST_ANSWER = 1'b0;
    localparam logic ST_ACK    = 1'b1;

    typedef struct packed {
        logic   status;
        t_node  common;
        t_level path;
        t_odd   ways;
    } t_answer;

    t_node   anc_mem [1:TREE_NODES][0:LEVELS-1];
    t_level  depth_mem [1:TREE_NODES];
    t_node   node_cnt;
    t_answer answer_q[$];
    int      fails;

    assign o_fail_count = fails;
    assign o_pending    = answer_q.size();

    initial begin
        for (int v = 1; v <= TREE_NODES; v++) begin
            depth_mem[v] = '0;
            for (int k = 0; k < LEVELS; k++) anc_mem[v][k] = '0;
        end
        fails = 0;
        node_cnt = 11'd1;
    end

    function automatic t_node hop(t_node v, int k);
        if (v == 0 || v > TREE_NODES) return '0;
        return anc_mem[v][k];
    endfunction

    function automatic t_level level_of(t_node v);
        if (v == 0 || v > TREE_NODES) return '0;
        return depth_mem[v];
    endfunction

    function automatic int nodes_used();
        return (node_cnt > TREE_NODES) ? TREE_NODES : int'(node_cnt);
    endfunction

    function automatic t_odd pow2_mod(int e);
        longint unsigned r, base;
        r = 1;
        base = 2;
        while (e != 0) begin
            if (e & 1) r = (r * base) % PRIME_MOD;
            base = (base * base) % PRIME_MOD;
            e = e >> 1;
        end
        return t_odd'(r);
    endfunction

    function automatic t_node common_of(t_node a, t_node b);
        t_level da, db, diff;
        t_node  t, ua, ub;
        da = level_of(a);
        db = level_of(b);
        if (da < db) begin
            t = a; a = b; b = t;
            diff = db - da;
        end else begin
            diff = da - db;
        end
        // Lift the deeper node to the level of the other
        for (int k = LEVELS - 1; k >= 0; k--)
            if (k < LEVEL_W && diff[k]) a = hop(a, k);
        if (a == b) return a;
        // Climb both while their ancestors differ
        for (int k = LEVELS - 1; k >= 0; k--) begin
            ua = hop(a, k);
            ub = hop(b, k);
            if (ua != ub && ua != 0 && ub != 0) begin
                a = ua;
                b = ub;
            end
        end
        return hop(a, 0);
    endfunction

    function automatic t_answer predict_answer(logic [1:0] cmd, t_node a, t_node b,
                                               t_level lvl);
        t_answer ans;
        t_node   mid, c;
        t_level  dc, d;
        int      lim;
        ans = '{status: ST_ACK, common: '0, path: '0, ways: '0};
        lim = nodes_used();
        if (cmd == CMD_LOAD) begin
            if (a != 0 && a <= TREE_NODES) begin
                anc_mem[a][0] = b;
                depth_mem[a] = lvl;
            end
        end else if (cmd == CMD_BUILD) begin
            for (int k = 1; k < LEVELS; k++)
                for (int v = 1; v <= lim; v++) begin
                    mid = hop(t_node'(v), k - 1);
                    anc_mem[v][k] = (mid != 0) ? hop(mid, k - 1) : '0;
                end
        end else if (cmd == CMD_QUERY) begin
            ans.status = ST_ANSWER;
            if (a != 0 && b != 0 && a <= lim && b <= lim) begin
                c = common_of(a, b);
                dc = level_of(c);
                d = level_of(a) - dc + level_of(b) - dc;
                ans.common = c;
                ans.path = d;
                ans.ways = (d == 0) ? '0 : pow2_mod(int'(d) - 1);
            end
        end
        return ans;
    endfunction

    // Compare results, then record new inputs and register writes
    always @(posedge i_clk) begin
        t_answer want, got;
        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready) begin
                got = '{status: i_m_tuser, common: i_m_tdata[10:0],
                        path: i_m_tdata[20:11], ways: i_m_tdata[50:21]};
                if (answer_q.size() == 0) begin
                    $display("%0t: result with none expected: actual %p", $time, got);
                    fails++;
                end else begin
                    want = answer_q.pop_front();
                    if (got.status !== want.status || got.common !== want.common ||
                        got.path !== want.path || got.ways !== want.ways) begin
                        $display("%0t: mismatch: expected %p actual %p", $time, want, got);
                        fails++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                answer_q.insert(answer_q.size(),
                                predict_answer(i_s_tuser, i_s_tdata[10:0],
                                               i_s_tdata[21:11], i_s_tdata[31:22]));
            if (i_cfg_valid && i_cfg_ready) node_cnt <= i_cfg_data;
        end
    end
endmodule

>>> test/tree_lca_path_parity_counter_tb.sv
// Top of the tree ancestor engine testbench: clock, reset, stimulus and verdict.
// Depends on tlpc_pkg, the engine and tree_lca_path_parity_counter_checker.
`timescale 1ns / 100ps
module tree_lca_path_parity_counter_tb;
    import tlpc_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam int IDLE_LIMIT = 150000;
    localparam int TAIL_CYCLES = 500;

    logic        i_clk, i_rst_n;
    logic        cfg_valid, cfg_ready;
    logic [10:0] cfg_data;
    logic        s_tvalid, s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid, m_tready;
    logic [55:0] m_tdata;
    logic        m_tuser;
    int          fail_count, pending;

    t_level tree_depth [1:1024];
    int     sent_items;
    int     idle_cycles;
    logic   tx_calm, rx_calm;
    int     rx_wait;

    tree_lca_path_parity_counter i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready),
        .s_axis_tdata(s_tdata), .s_axis_tuser(s_tuser),
        .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready),
        .m_axis_tdata(m_tdata), .m_axis_tuser(m_tuser)
    );

    tree_lca_path_parity_counter_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tuser(m_tuser),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
    end

    always #6 i_clk = ~i_clk;

    // Receiver: random stall before each result, with calm stretches
    always @(posedge i_clk) begin
        int w;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            rx_wait <= 0;
            rx_calm <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            if ($urandom_range(0, 29) == 0) rx_calm <= ~rx_calm;
            w = rx_calm ? 0 : $urandom_range(0, 19);
            rx_wait <= w;
            m_tready <= (w == 0);
        end else if (rx_wait != 0) begin
            rx_wait <= rx_wait - 1;
            m_tready <= (rx_wait == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog on cycles with no transaction at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tree_lca_path_parity_counter_tb NOT OK");
                $finish;
            end
        end
    end

    task automatic send_item(logic [1:0] cmd, t_node a, t_node b, t_level lvl);
        int gap;
        if ($urandom_range(0, 39) == 0) tx_calm = ~tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tdata <= {lvl, b, a};
        s_tuser <= cmd;
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
        sent_items++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_count(logic [10:0] value);
        drain();
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Parent kept inside the allowed set: root, a node from 1 to n, or outside the table
    function automatic t_node pick_parent(int n);
        case ($urandom_range(0, 3))
            0: return '0;
            1: return t_node'($urandom_range(1025, 2047));
            default: return t_node'($urandom_range(1, n));
        endcase
    endfunction

    task automatic load_tree(int n, int noise_pct);
        t_node p;
        t_level lvl;
        for (int v = 1; v <= n; v++) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                p = pick_parent(n);
                lvl = t_level'($urandom());
            end else if (v == 1) begin
                p = '0;
                lvl = ($urandom_range(0, 3) == 0) ? t_level'($urandom()) : '0;
            end else begin
                p = t_node'($urandom_range(1, v - 1));
                lvl = tree_depth[p] + 1'b1;
            end
            tree_depth[v] = lvl;
            send_item(CMD_LOAD, t_node'(v), p, lvl);
        end
        send_item(CMD_BUILD, t_node'($urandom()), t_node'($urandom()), t_level'($urandom()));
    endtask

    task automatic random_op(int n);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80 && n > 0)
            send_item(CMD_QUERY, t_node'($urandom_range(1, n)), t_node'($urandom_range(1, n)),
                      t_level'($urandom()));
        else if (pick < 88)
            send_item(CMD_QUERY, t_node'($urandom()), t_node'($urandom()), t_level'($urandom()));
        else if (pick < 92 && n > 0)
            send_item(CMD_LOAD, t_node'($urandom_range(1, n)), pick_parent(n),
                      t_level'($urandom()));
        else if (pick < 95)
            send_item(CMD_LOAD, ($urandom_range(0, 1) != 0) ? t_node'(0)
                      : t_node'($urandom_range(1025, 2047)), t_node'($urandom()),
                      t_level'($urandom()));
        else if (pick < 97)
            send_item(CMD_SPARE, t_node'($urandom()), t_node'($urandom()), t_level'($urandom()));
        else
            send_item(CMD_BUILD, t_node'($urandom()), t_node'($urandom()), t_level'($urandom()));
    endtask

    initial begin
        int n, ops;
        sent_items = 0;
        tx_calm = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single root at reset count, unused command, bad loads and endpoints
        send_item(CMD_LOAD, 11'd1, 11'd0, 10'd0);
        send_item(CMD_BUILD, 11'd0, 11'd0, 10'd0);
        send_item(CMD_QUERY, 11'd1, 11'd1, 10'h3FF);
        send_item(CMD_SPARE, 11'h7FF, 11'h7FF, 10'h3FF);
        send_item(CMD_LOAD, 11'd0, 11'h7FF, 10'h3FF);
        send_item(CMD_LOAD, 11'h7FF, 11'd5, 10'd7);
        send_item(CMD_LOAD, 11'd1025, 11'd1, 10'd1);
        send_item(CMD_QUERY, 11'd0, 11'd1, 10'd0);
        send_item(CMD_QUERY, 11'd1, 11'h7FF, 10'd0);
        send_item(CMD_QUERY, 11'd2, 11'd1, 10'd0);

        // No node in use
        write_count(11'd0);
        send_item(CMD_BUILD, 11'd0, 11'd0, 10'd0);
        send_item(CMD_QUERY, 11'd1, 11'd1, 10'd0);

        // Small chain: parent outside the table, depth that wraps
        write_count(11'd4);
        send_item(CMD_LOAD, 11'd1, 11'h7FF, 10'h3FE);
        send_item(CMD_LOAD, 11'd2, 11'd1, 10'h3FF);
        send_item(CMD_LOAD, 11'd3, 11'd2, 10'd0);
        send_item(CMD_LOAD, 11'd4, 11'd2, 10'd0);
        send_item(CMD_BUILD, 11'd0, 11'd0, 10'd0);
        send_item(CMD_QUERY, 11'd3, 11'd4, 10'd0);
        send_item(CMD_QUERY, 11'd1, 11'd3, 10'd0);
        send_item(CMD_QUERY, 11'd4, 11'd1, 10'd0);
        send_item(CMD_QUERY, 11'd5, 11'd1, 10'd0);

        // Count above the table size acts as the full table
        write_count(11'h7FF);
        send_item(CMD_QUERY, 11'd3, 11'd4, 10'd0);
        send_item(CMD_QUERY, 11'd1025, 11'd1, 10'd0);
        send_item(CMD_QUERY, 11'd2, 11'h7FF, 10'd0);
        write_count(11'd1024);
        send_item(CMD_QUERY, 11'd4, 11'd2, 10'd0);
        send_item(CMD_QUERY, 11'd1025, 11'd1, 10'd0);

        // Random phases of small trees
        sent_items = 0;
        while (sent_items < 600) begin
            case ($urandom_range(0, 9))
                0: n = $urandom_range(0, 1);
                1: n = $urandom_range(41, 120);
                default: n = $urandom_range(2, 40);
            endcase
            write_count(11'(n));
            load_tree(n, ($urandom_range(0, 3) == 0) ? 30 : 0);
            ops = $urandom_range(10, 40);
            for (int i = 0; i < ops; i++) begin
                random_op(n);
                if ($urandom_range(0, 99) == 0) drain();
            end
        end

        // Wait for every result, then let any late output show up
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("tree_lca_path_parity_counter_tb OK");
        else
            $display("tree_lca_path_parity_counter_tb NOT OK");
        $finish;
    end
endmodule
